// File: rtl/soc_pkg.sv
// Shared types and constants for the segment versus obstacle collision check.
package soc_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int OBST_W = 64;
  localparam logic [9:0] MARGIN_RESET = 10'd128;

  typedef enum logic [1:0] {
    KIND_EMPTY    = 2'd0,
    KIND_CIRCLE   = 2'd1,
    KIND_RECT     = 2'd2,
    KIND_BOUNDARY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_INSIDE = 2'd1,
    CAUSE_EDGE   = 2'd2,
    CAUSE_CIRCLE = 2'd3
  } cause_t;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [14:0] h;
    logic [14:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } obst_t;

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] ex;
    logic [15:0] ey;
    logic [16:0] dx;
    logic [16:0] dy;
    logic [33:0] d2;
    logic [9:0]  m;
  } query_t;

  typedef struct packed {
    logic  valid;
    logic  last;
    obst_t obst;
  } slot_req_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic inside_hit;
    logic edge_hit;
    logic circle_hit;
  } slot_res_t;

endpackage

// File: rtl/soc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module soc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/soc_slot_eval.sv
// Six-stage pipeline that tests one obstacle slot against the query segment.
module soc_slot_eval (
  input  logic               clk,
  input  logic               rst_n,
  input  soc_pkg::query_t    q,
  input  soc_pkg::slot_req_t req,
  output soc_pkg::slot_res_t res
);

  function automatic logic edge_cross(input logic signed [40:0] den,
                                      input logic signed [40:0] n,
                                      input logic signed [40:0] mm);
    logic ok;
    begin
      ok = 1'b0;
      if (den > 0) begin
        ok = (n <= den) && (mm >= 0) && (mm <= den);
      end else if (den < 0) begin
        ok = (n == 0) && (mm <= 0) && (mm >= den);
      end
      return ok;
    end
  endfunction

  function automatic logic signed [40:0] abs41(input logic signed [39:0] v);
    logic signed [40:0] e;
    begin
      e = 41'(v);
      return (e < 0) ? -e : e;
    end
  endfunction

  // Stage A: inflated box corners and offsets.
  logic signed [19:0] xa, ya, wa, ha, ma, sxa, sya, exa, eya, x0, x1, y0, y1;
  logic signed [19:0] dx20, dy20;
  logic signed [19:0] rr_r, wb_r, hb_r, ux0_r, ux1_r, uy0_r, uy1_r, vx0_r, vy0_r;
  logic signed [19:0] dxs_r, dys_r, dxe_r, dye_r;
  logic               va_r, la_r;
  soc_pkg::kind_t     ka_r;

  assign xa = 20'($signed(req.obst.x));
  assign ya = 20'($signed(req.obst.y));
  assign wa = 20'($signed({1'b0, req.obst.w}));
  assign ha = 20'($signed({1'b0, req.obst.h}));
  assign ma = 20'($signed({1'b0, q.m}));
  assign sxa = 20'($signed(q.sx));
  assign sya = 20'($signed(q.sy));
  assign exa = 20'($signed(q.ex));
  assign eya = 20'($signed(q.ey));
  assign dx20 = 20'($signed(q.dx));
  assign dy20 = 20'($signed(q.dy));
  assign x0 = xa - ma;
  assign y0 = ya - ma;
  assign x1 = xa + wa + ma;
  assign y1 = ya + ha + ma;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= req.valid;
    end
    la_r  <= req.last;
    ka_r  <= req.obst.kind;
    rr_r  <= wa + ma;
    wb_r  <= wa + ma + ma;
    hb_r  <= ha + ma + ma;
    ux0_r <= sxa - x0;
    ux1_r <= sxa - x1;
    uy0_r <= sya - y0;
    uy1_r <= sya - y1;
    vx0_r <= exa - x0;
    vy0_r <= eya - y0;
    dxs_r <= sxa - xa;
    dys_r <= sya - ya;
    dxe_r <= exa - xa;
    dye_r <= eya - ya;
  end

  // Stage B: box containment and all products.
  logic               box_in;
  logic               vb_r, lb_r, boxb_r;
  soc_pkg::kind_t     kb_r;
  logic signed [39:0] sqs0_r, sqs1_r, sqe0_r, sqe1_r, rr2_r, pd0_r, pd1_r, cx0_r, cx1_r;
  logic signed [39:0] wdy_r, hdx_r, wy0_r, wy1_r, hx1_r, hx0_r;
  logic signed [39:0] x0dy_r, x1dy_r, y0dx_r, y1dx_r;

  assign box_in = ((ux0_r >= 0) && (ux0_r <= wb_r) && (uy0_r >= 0) && (uy0_r <= hb_r))
               || ((vx0_r >= 0) && (vx0_r <= wb_r) && (vy0_r >= 0) && (vy0_r <= hb_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    lb_r   <= la_r;
    kb_r   <= ka_r;
    boxb_r <= box_in;
    sqs0_r <= dxs_r * dxs_r;
    sqs1_r <= dys_r * dys_r;
    sqe0_r <= dxe_r * dxe_r;
    sqe1_r <= dye_r * dye_r;
    rr2_r  <= rr_r * rr_r;
    pd0_r  <= dxs_r * dx20;
    pd1_r  <= dys_r * dy20;
    cx0_r  <= dy20 * dxs_r;
    cx1_r  <= dx20 * dys_r;
    wdy_r  <= wb_r * dy20;
    hdx_r  <= hb_r * dx20;
    wy0_r  <= wb_r * uy0_r;
    wy1_r  <= wb_r * uy1_r;
    hx1_r  <= hb_r * ux1_r;
    hx0_r  <= hb_r * ux0_r;
    x0dy_r <= ux0_r * dy20;
    x1dy_r <= ux1_r * dy20;
    y0dx_r <= uy0_r * dx20;
    y1dx_r <= uy1_r * dx20;
  end

  // Stage C: circle containment, edge crossings and projection range.
  logic signed [40:0] rr2c, ss, se, pc, crs, crabs, d2s;
  logic signed [40:0] mm0, mm1, mm2, mm3;
  logic               circ_in, inside_c, edge_c, pok_c;
  logic               vc_r, lc_r, insc_r, edgec_r, pokc_r;
  soc_pkg::kind_t     kc_r;
  logic [33:0]        cr_r;
  logic [30:0]        rr2c_r;

  assign rr2c = 41'(rr2_r);
  assign ss = 41'(sqs0_r) + 41'(sqs1_r);
  assign se = 41'(sqe0_r) + 41'(sqe1_r);
  assign circ_in = (ss <= rr2c) || (se <= rr2c);
  assign inside_c = ((kb_r == soc_pkg::KIND_CIRCLE) && circ_in)
                 || (((kb_r == soc_pkg::KIND_RECT) || (kb_r == soc_pkg::KIND_BOUNDARY))
                     && boxb_r);
  assign pc = -(41'(pd0_r) + 41'(pd1_r));
  assign d2s = $signed({7'd0, q.d2});
  assign pok_c = (q.d2 != '0) && (pc >= 0) && (pc <= d2s);
  assign crs = 41'(cx0_r) - 41'(cx1_r);
  assign crabs = (crs < 0) ? -crs : crs;
  assign mm0 = 41'(y0dx_r) - 41'(x0dy_r);
  assign mm1 = 41'(y0dx_r) - 41'(x1dy_r);
  assign mm2 = 41'(y1dx_r) - 41'(x1dy_r);
  assign mm3 = 41'(y1dx_r) - 41'(x0dy_r);
  assign edge_c = (kb_r == soc_pkg::KIND_RECT)
               && (edge_cross(-41'(wdy_r), abs41(wy0_r), mm0)
                || edge_cross(41'(hdx_r), abs41(hx1_r), mm1)
                || edge_cross(41'(wdy_r), abs41(wy1_r), mm2)
                || edge_cross(-41'(hdx_r), abs41(hx0_r), mm3));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
    lc_r    <= lb_r;
    kc_r    <= kb_r;
    insc_r  <= inside_c;
    edgec_r <= edge_c;
    pokc_r  <= pok_c;
    cr_r    <= crabs[33:0];
    rr2c_r  <= rr2_r[30:0];
  end

  // Stage D: partial products of both sides of the circle distance test.
  logic               vd_r, ld_r, insd_r, edged_r, pokd_r;
  soc_pkg::kind_t     kd_r;
  logic [33:0]        chh_r, chl_r, cll_r;
  logic [31:0]        rhdh_r, rhdl_r;
  logic [32:0]        rldh_r, rldl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= vc_r;
    end
    ld_r    <= lc_r;
    kd_r    <= kc_r;
    insd_r  <= insc_r;
    edged_r <= edgec_r;
    pokd_r  <= pokc_r;
    chh_r   <= 34'(cr_r[33:17]) * 34'(cr_r[33:17]);
    chl_r   <= 34'(cr_r[33:17]) * 34'(cr_r[16:0]);
    cll_r   <= 34'(cr_r[16:0]) * 34'(cr_r[16:0]);
    rhdh_r  <= 32'(rr2c_r[30:16]) * 32'(q.d2[33:17]);
    rhdl_r  <= 32'(rr2c_r[30:16]) * 32'(q.d2[16:0]);
    rldh_r  <= 33'(rr2c_r[15:0]) * 33'(q.d2[33:17]);
    rldl_r  <= 33'(rr2c_r[15:0]) * 33'(q.d2[16:0]);
  end

  // Stage E: recombine the partial products.
  logic               ve_r, le_r, inse_r, edgee_r, poke_r;
  soc_pkg::kind_t     ke_r;
  logic [69:0]        lhs_r, rhs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else begin
      ve_r <= vd_r;
    end
    le_r    <= ld_r;
    ke_r    <= kd_r;
    inse_r  <= insd_r;
    edgee_r <= edged_r;
    poke_r  <= pokd_r;
    lhs_r   <= (70'(chh_r) << 34) + (70'(chl_r) << 18) + 70'(cll_r);
    rhs_r   <= (70'(rhdh_r) << 33) + (70'(rhdl_r) << 16) + (70'(rldh_r) << 17)
             + 70'(rldl_r);
  end

  // Stage F: final compare and result register.
  soc_pkg::slot_res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else begin
      res_r.valid <= ve_r;
    end
    res_r.last       <= le_r;
    res_r.inside_hit <= inse_r;
    res_r.edge_hit   <= edgee_r;
    res_r.circle_hit <= (ke_r == soc_pkg::KIND_CIRCLE) && poke_r && (lhs_r <= rhs_r);
  end

  assign res = res_r;

endmodule

// File: rtl/segment_obstacle_collision_check.sv
// Top level: obstacle table, query sequencer and result register.
//
//   Channel | Direction | Handshake          | Payload
//   in_*    | input     | in_valid/in_stall  | mode, slot, obstacle fields, segment
//   out_*   | output    | out_valid/out_stall| collides, cause
//   cfg_*   | input     | cfg_valid/cfg_ready| inflation_margin
//
// A write transfer is taken at once and the block stays ready.
// A query stalls the input after its transfer while the block forms the
// segment length, reads each obstacle slot from memory, drains the read
// register and the six-stage slot pipeline, and loads the result, so the
// next query is taken only after all of that and any wait for the result
// register to drain.
// Reset is synchronous; it empties every slot and sets the margin to 0.5 m.
// A stalled result holds in the output register while write items go on.
module segment_obstacle_collision_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [3:0]  in_slot,
  input  logic [1:0]  in_obstacle_kind,
  input  logic signed [15:0] in_obstacle_x,
  input  logic signed [15:0] in_obstacle_y,
  input  logic [14:0] in_obstacle_width,
  input  logic [14:0] in_obstacle_height,
  input  logic signed [15:0] in_seg_start_x,
  input  logic signed [15:0] in_seg_start_y,
  input  logic signed [15:0] in_seg_end_x,
  input  logic signed [15:0] in_seg_end_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_collides,
  output logic [1:0]  out_cause,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_inflation_margin
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  soc_pkg::query_t              q_r, q_nxt;
  logic [9:0]                   margin_r;
  logic [soc_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [soc_pkg::SLOTS-1:0]    vld_r;
  logic                         rd_v_r, rd_last_r, rd_vld_r;
  logic                         hit_in_r, hit_edge_r, hit_circ_r;
  logic                         out_valid_r, out_valid_nxt;
  soc_pkg::cause_t              cause_r, cause_nxt;
  logic                         accept, wr_en, q_accept, issue, last_issue;
  logic [soc_pkg::SLOT_W-1:0]   waddr, raddr;
  soc_pkg::obst_t               wr_obst, rd_obst;
  logic [soc_pkg::OBST_W-1:0]   rd_data;
  soc_pkg::slot_req_t           req;
  soc_pkg::slot_res_t           res;
  logic signed [16:0]           dxs, dys;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign q_accept  = accept && (in_mode == soc_pkg::MODE_QUERY);
  assign wr_en     = accept && (in_mode == soc_pkg::MODE_WRITE)
                  && (int'(in_slot) < soc_pkg::SLOTS);
  assign waddr     = soc_pkg::SLOT_W'(in_slot);
  assign raddr     = cnt_r[soc_pkg::SLOT_W-1:0];
  assign issue     = (state_r == ST_RUN);
  assign last_issue = (cnt_r == soc_pkg::CNT_W'(soc_pkg::SLOTS - 1));

  assign wr_obst.kind = soc_pkg::kind_t'(in_obstacle_kind);
  assign wr_obst.x    = in_obstacle_x;
  assign wr_obst.y    = in_obstacle_y;
  assign wr_obst.w    = in_obstacle_width;
  assign wr_obst.h    = in_obstacle_height;

  soc_ram #(
    .WIDTH(soc_pkg::OBST_W),
    .DEPTH(soc_pkg::SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(waddr),
    .wdata(wr_obst),
    .raddr(raddr),
    .rdata(rd_data)
  );

  always_comb begin
    rd_obst = soc_pkg::obst_t'(rd_data);
    if (!rd_vld_r) begin
      rd_obst.kind = soc_pkg::KIND_EMPTY;
    end
    req.valid = rd_v_r;
    req.last  = rd_last_r;
    req.obst  = rd_obst;
  end

  soc_slot_eval u_eval (
    .clk  (clk),
    .rst_n(rst_n),
    .q    (q_r),
    .req  (req),
    .res  (res)
  );

  assign dxs = 17'(in_seg_end_x) - 17'(in_seg_start_x);
  assign dys = 17'(in_seg_end_y) - 17'(in_seg_start_y);

  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cause_nxt     = cause_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (q_accept) begin
          q_nxt.sx  = in_seg_start_x;
          q_nxt.sy  = in_seg_start_y;
          q_nxt.ex  = in_seg_end_x;
          q_nxt.ey  = in_seg_end_y;
          q_nxt.dx  = dxs;
          q_nxt.dy  = dys;
          q_nxt.m   = margin_r;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        q_nxt.d2  = 34'($signed(q_r.dx) * $signed(q_r.dx))
                  + 34'($signed(q_r.dy) * $signed(q_r.dy));
        cnt_nxt   = '0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res.valid && res.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (hit_in_r) begin
            cause_nxt = soc_pkg::CAUSE_INSIDE;
          end else if (hit_edge_r) begin
            cause_nxt = soc_pkg::CAUSE_EDGE;
          end else if (hit_circ_r) begin
            cause_nxt = soc_pkg::CAUSE_CIRCLE;
          end else begin
            cause_nxt = soc_pkg::CAUSE_NONE;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      margin_r    <= soc_pkg::MARGIN_RESET;
      vld_r       <= '0;
      rd_v_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      rd_v_r      <= issue;
      if (cfg_valid && cfg_ready) begin
        margin_r <= cfg_inflation_margin;
      end
      if (wr_en) begin
        vld_r[waddr] <= 1'b1;
      end
    end
    q_r       <= q_nxt;
    cause_r   <= cause_nxt;
    rd_last_r <= last_issue;
    rd_vld_r  <= vld_r[raddr];
    if (q_accept) begin
      hit_in_r   <= 1'b0;
      hit_edge_r <= 1'b0;
      hit_circ_r <= 1'b0;
    end else if (res.valid) begin
      hit_in_r   <= hit_in_r | res.inside_hit;
      hit_edge_r <= hit_edge_r | res.edge_hit;
      hit_circ_r <= hit_circ_r | res.circle_hit;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_cause    = cause_r;
  assign out_collides = (cause_r != soc_pkg::CAUSE_NONE);

endmodule

// File: rtl/soc_checker.sv
// Port-level checks for the collision check block, bound to the top level.
module soc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_mode,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_collides,
  input logic [1:0] out_cause
);

  // A stalled result keeps its value until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cause) && $stable(out_collides))
    else $error("result changed while stalled");

  // The collision flag agrees with the cause code.
  a_flag_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_collides == (out_cause != soc_pkg::CAUSE_NONE)))
    else $error("collision flag disagrees with cause");

  // A query keeps the input side busy on the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == soc_pkg::MODE_QUERY) |=> in_stall)
    else $error("input taken right after a query");

  // A write transfer leaves the block ready for the next item.
  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == soc_pkg::MODE_WRITE) |=> !in_stall)
    else $error("block busy after a write");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind segment_obstacle_collision_check soc_checker u_soc_checker (.*);
